FILE: rtl/abd_pkg.sv
// shared types, tables and constants of the address keyed byte descrambler
`timescale 1ns / 1ps

package abd_pkg;

    // default address width
    localparam int DEF_ADDR_WIDTH = 14;

    // address bits that pick the method, and the bit that rotates it
    localparam logic [9:0] SEL_MASK  = 10'h2A5;
    localparam int         SHIFT_POS = 11;

    localparam int NUM_METHODS = 6;
    localparam int HALF_METHODS = NUM_METHODS / 2;

    // method index, zero based (method 1 of the scheme is index 0)
    typedef logic [2:0] t_method;

    localparam t_method METHOD_IDENT = 3'd0;

    typedef logic [2:0] t_bit_idx;
    typedef t_bit_idx [7:0] t_perm;

    // source bit for each output bit, per method (element i feeds output bit i)
    localparam t_perm SRC_BIT [NUM_METHODS] = '{
        '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd2, 3'd3, 3'd1, 3'd7, 3'd4, 3'd6, 3'd0, 3'd5},
        '{3'd5, 3'd0, 3'd4, 3'd3, 3'd7, 3'd1, 3'd2, 3'd6},
        '{3'd7, 3'd6, 3'd3, 3'd4, 3'd5, 3'd2, 3'd1, 3'd0},
        '{3'd2, 3'd3, 3'd4, 3'd7, 3'd1, 3'd6, 3'd0, 3'd5},
        '{3'd5, 3'd0, 3'd4, 3'd3, 3'd7, 3'd1, 3'd2, 3'd6}
    };

    // output bits inverted after the permutation, per method
    localparam logic [7:0] INV_MASK [NUM_METHODS] = '{
        8'h00, 8'h6E, 8'hA4, 8'h20, 8'h4E, 8'h8C
    };

    // method picked by the masked address bits, identity when not listed
    function automatic t_method base_method(input logic [9:0] sel);
        t_method m;
        unique case (sel)
            10'h004, 10'h005, 10'h020, 10'h085, 10'h0A0:
                m = 3'd1;
            10'h001, 10'h021, 10'h025, 10'h080, 10'h084, 10'h0A1, 10'h0A5:
                m = 3'd2;
            10'h205, 10'h280, 10'h284:
                m = 3'd3;
            10'h200, 10'h204, 10'h220, 10'h224, 10'h281, 10'h285, 10'h2A0,
            10'h2A4:
                m = 3'd4;
            10'h201, 10'h221, 10'h225, 10'h2A1, 10'h2A5:
                m = 3'd5;
            default:
                m = METHOD_IDENT;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/address_keyed_byte_descrambler.sv
// top level of the address keyed byte descrambler
`timescale 1ns / 1ps

// usage
// - a word (rom address and cipher byte) is taken at each rising edge with start
//   high and busy low; busy is held low, so a word may come every cycle
// - the decrypted byte appears on o_plain_byte with o_valid high for exactly one
//   cycle, starting at the edge after the word was taken (the input register
//   loads on the taking edge, the result register on the next one)
// - throughput is one word per cycle; the only logic between the two registers
//   is the method decode and one 8 bit permutation with inversion
// - the receiver cannot stall: every result is consumed in its strobe cycle
// - synchronous active-low reset clears the valid flags; no word in flight
//   survives reset, and no result is shown until new words arrive
// - only the low ADDR_WIDTH address bits matter; bits 9,7,5,2,0 pick the
//   method and bit 11 rotates it by three
// - the block keeps no state between words
module address_keyed_byte_descrambler
    import abd_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_WIDTH-1:0] i_rom_address,
    input  logic [7:0]            i_cipher_byte,
    output logic                  o_valid,
    output logic [7:0]            o_plain_byte
);

    // input register
    logic                  r_in_vld;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [7:0]            r_byte;

    // result register
    logic                  r_out_vld;
    logic [7:0]            r_plain;
    logic [7:0]            n_plain;

    t_method method;

    // the block never holds words off
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start;
            r_out_vld <= r_in_vld;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_addr <= i_rom_address;
            r_byte <= i_cipher_byte;
        end
        if (r_in_vld) begin
            r_plain <= n_plain;
        end
    end

    // method decode from the registered address
    abd_sel #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_sel (
        .i_addr   (r_addr),
        .o_method (method)
    );

    // permutation and inversion of the registered byte
    abd_perm u_perm (
        .i_method (method),
        .i_byte   (r_byte),
        .o_byte   (n_plain)
    );

    assign o_valid      = r_out_vld;
    assign o_plain_byte = r_plain;

endmodule

FILE: rtl/abd_sel.sv
// method selection from the rom address
`timescale 1ns / 1ps

module abd_sel
    import abd_pkg::*;
#(
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic [ADDR_WIDTH-1:0] i_addr,
    output t_method               o_method
);

    t_method base;

    always_comb begin
        base = base_method(i_addr[9:0] & SEL_MASK);
        // bit 11 advances by three, wrapping within six methods
        if (i_addr[SHIFT_POS]) begin
            if (base < t_method'(HALF_METHODS)) begin
                o_method = base + t_method'(HALF_METHODS);
            end else begin
                o_method = base - t_method'(HALF_METHODS);
            end
        end else begin
            o_method = base;
        end
    end

endmodule

FILE: rtl/abd_perm.sv
// bit permutation and inversion of one byte
`timescale 1ns / 1ps

module abd_perm
    import abd_pkg::*;
(
    input  t_method    i_method,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] perm;
    t_perm      src;

    always_comb begin
        src = SRC_BIT[i_method];
        for (int i = 0; i < 8; i++) begin
            perm[i] = i_byte[src[i]];
        end
        o_byte = perm ^ INV_MASK[i_method];
    end

endmodule

FILE: tb/plain_byte_checker.sv
// checker for the address keyed byte descrambler: predicts each plain byte and compares
`timescale 1ns / 1ps

module plain_byte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [13:0] i_rom_address,
    input  logic [7:0]  i_cipher_byte,
    input  logic        o_valid,
    input  logic [7:0]  o_plain_byte,
    output int          o_fail_count,
    output int          o_pending
);

    // zero based descrambling methods, the first one passes the byte through
    typedef enum logic [2:0] {
        MTH_IDENT, MTH_SECOND, MTH_THIRD, MTH_FOURTH, MTH_FIFTH, MTH_SIXTH
    } t_scheme;

    localparam int         N_SCHEMES = 6;
    localparam logic [9:0] KEY_BITS  = 10'h2A5;
    localparam int         ROT_BIT   = 11;

    // source bit that feeds output bit i, per method
    localparam logic [2:0] FEED [N_SCHEMES][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd5, 3'd0, 3'd6, 3'd4, 3'd7, 3'd1, 3'd3, 3'd2},
        '{3'd6, 3'd2, 3'd1, 3'd7, 3'd3, 3'd4, 3'd0, 3'd5},
        '{3'd0, 3'd1, 3'd2, 3'd5, 3'd4, 3'd3, 3'd6, 3'd7},
        '{3'd5, 3'd0, 3'd6, 3'd1, 3'd7, 3'd4, 3'd3, 3'd2},
        '{3'd6, 3'd2, 3'd1, 3'd7, 3'd3, 3'd4, 3'd0, 3'd5}
    };

    // bits flipped after the shuffle
    localparam logic [7:0] FLIP [N_SCHEMES] = '{
        8'h00, 8'h6E, 8'hA4, 8'h20, 8'h4E, 8'h8C
    };

    typedef struct {
        logic [13:0] addr;
        logic [7:0]  cipher;
        logic [7:0]  plain;
    } t_plain_exp;

    t_plain_exp plain_q[$];

    function automatic t_scheme pick_scheme(input logic [13:0] addr);
        t_scheme base;
        int      idx;
        case (addr[9:0] & KEY_BITS)
            10'h004, 10'h005, 10'h020, 10'h085, 10'h0A0:
                base = MTH_SECOND;
            10'h001, 10'h021, 10'h025, 10'h080, 10'h084, 10'h0A1, 10'h0A5:
                base = MTH_THIRD;
            10'h205, 10'h280, 10'h284:
                base = MTH_FOURTH;
            10'h200, 10'h204, 10'h220, 10'h224, 10'h281, 10'h285, 10'h2A0, 10'h2A4:
                base = MTH_FIFTH;
            10'h201, 10'h221, 10'h225, 10'h2A1, 10'h2A5:
                base = MTH_SIXTH;
            default:
                base = MTH_IDENT;
        endcase
        idx = int'(base);
        if (addr[ROT_BIT])
            idx = (idx + N_SCHEMES / 2) % N_SCHEMES;
        return t_scheme'(idx);
    endfunction

    function automatic logic [7:0] descramble_byte(input logic [13:0] addr,
                                                   input logic [7:0] cipher);
        t_scheme    m;
        logic [7:0] shuffled;
        m = pick_scheme(addr);
        for (int i = 0; i < 8; i++)
            shuffled[i] = cipher[FEED[int'(m)][i]];
        return shuffled ^ FLIP[int'(m)];
    endfunction

    always @(posedge i_clk) begin
        t_plain_exp exp_w;
        t_plain_exp new_w;
        int         delta;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            delta = 0;
            // result leaves before a word taken on the same edge could be due
            if (o_valid) begin
                if (plain_q.size() == 0) begin
                    $display("%0t: result %02h with nothing expected", $time, o_plain_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = plain_q.pop_front();
                    delta = delta - 1;
                    if (o_plain_byte !== exp_w.plain) begin
                        $display("%0t: addr %04h cipher %02h plain exp %02h got %02h",
                                 $time, exp_w.addr, exp_w.cipher, exp_w.plain,
                                 o_plain_byte);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                new_w.addr   = i_rom_address;
                new_w.cipher = i_cipher_byte;
                new_w.plain  = descramble_byte(i_rom_address, i_cipher_byte);
                plain_q.push_back(new_w);
                delta = delta + 1;
            end
            o_pending <= o_pending + delta;
        end
    end

endmodule

FILE: tb/tb_top.sv
// top of the descrambler testbench: clock, reset, word stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 1000;  // cycles with no word moving
    localparam int RAND_WORDS  = 1400;
    localparam int TAIL_CYCLES = 4;     // two register stages plus margin

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [13:0] i_rom_address;
    logic [7:0]  i_cipher_byte;
    logic        o_valid;
    logic [7:0]  o_plain_byte;
    int          fail_count;
    int          pending;
    int          quiet_cycles;

    address_keyed_byte_descrambler #(
        .ADDR_WIDTH(14)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_rom_address(i_rom_address),
        .i_cipher_byte(i_cipher_byte),
        .o_valid      (o_valid),
        .o_plain_byte (o_plain_byte)
    );

    plain_byte_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_rom_address(i_rom_address),
        .i_cipher_byte(i_cipher_byte),
        .o_valid      (o_valid),
        .o_plain_byte (o_plain_byte),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog: nothing taken and nothing delivered for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("address_keyed_byte_descrambler regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, with random idle cycles ahead of it when allowed;
    // returns on the edge that takes it
    task automatic send_word(input logic [13:0] addr, input logic [7:0] cipher,
                             input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 37) begin
            start <= 1'b0;
            i_rom_address <= 14'($urandom());
            i_cipher_byte <= 8'($urandom());
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_rom_address <= addr;
        i_cipher_byte <= cipher;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // representative key patterns: identity, then methods two to six
    localparam logic [13:0] KEY_PICKS [6] = '{
        14'h0000, 14'h0004, 14'h0001, 14'h0205, 14'h0200, 14'h0201
    };

    initial begin
        bit quiet_run;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_rom_address <= '0;
        i_cipher_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every method with and without the rotate bit,
        // one set bit walking through the byte so each shuffle shows
        for (int m = 0; m < 6; m++) begin
            send_word(KEY_PICKS[m], 8'h01 << m, 1'b1);
            send_word(KEY_PICKS[m] | 14'h0800, 8'h80 >> m, 1'b1);
        end
        // patterns outside the table fall back to identity; with the rotate bit set that becomes the fourth method
        send_word(14'h0024, 8'h5A, 1'b1);
        send_word(14'h0824, 8'hA5, 1'b1);
        send_word(14'h0081, 8'h3C, 1'b1);
        // address and byte extremes
        send_word(14'h0000, 8'h00, 1'b1);
        send_word(14'h0000, 8'hFF, 1'b1);
        send_word(14'h3FFF, 8'h00, 1'b1);
        send_word(14'h3FFF, 8'hFF, 1'b1);
        // key bits clear: top bits only, then every bit but the key bits and bit 11
        send_word(14'h3000, 8'hC3, 1'b1);
        send_word(14'h37FF & ~14'h02A5, 8'h96, 1'b1);

        // random words, with a long stretch back to back
        for (int n = 0; n < RAND_WORDS; n++) begin
            quiet_run = (n >= 500 && n < 800);
            send_word(14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)),
                      !quiet_run);
        end
        start <= 1'b0;

        // drain, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("address_keyed_byte_descrambler regression: pass");
        else
            $display("address_keyed_byte_descrambler regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/abd_pkg.sv
rtl/abd_sel.sv
rtl/abd_perm.sv
rtl/address_keyed_byte_descrambler.sv
tb/plain_byte_checker.sv
tb/tb_top.sv
